@@ sv/lat_pkg.sv @@
// Shared widths, command codes and the cell result record for the aging life block.
package lat_pkg;

	localparam int AGE_W         = 4;
	localparam int COORD_W       = 6;
	localparam int CMD_W         = 2;
	localparam int CHANGE_W      = 13;
	localparam int GEN_W         = 32;
	localparam int WEIGHT_W      = 8;
	localparam int NBR_W         = 4;
	localparam int GRID_COLS_DEF = 64;
	localparam int GRID_ROWS_DEF = 64;

	localparam logic [AGE_W-1:0]    AGE_MAX      = 4'd15;
	localparam logic [AGE_W-1:0]    AGE_BORN     = 4'd1;
	localparam logic [NBR_W-1:0]    NBR_BIRTH    = 4'd3;
	localparam logic [NBR_W-1:0]    NBR_SURVIVE  = 4'd2;
	localparam logic [CHANGE_W-1:0] CHANGE_MAX   = 13'd8191;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 8'd8;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 2'd0,
		CMD_STEP  = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [AGE_W-1:0] age;
		logic             changed;
	} cell_res_t;

endpackage

@@ sv/lat_bank.sv @@
// Grid bank: one write port and two registered read ports.
module lat_bank #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = 4
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_a_q;
	logic [DATA_W-1:0] rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

@@ sv/lat_cell_unit.sv @@
// Cell update unit: three-row line buffer window and the aging life rule.
module lat_cell_unit #(
	parameter int GRID_COLS = 64
) (
	input  logic                      clk,
	input  logic                      shift_en,
	input  logic                      live_in,
	input  logic [lat_pkg::AGE_W-1:0] center_age,
	output lat_pkg::cell_res_t        res
);
	import lat_pkg::*;

	localparam int LINE = GRID_COLS + 2;
	localparam int TAPS = 2 * LINE + 2;

	logic [TAPS-1:0]  line_q;
	logic [7:0]       nbr;
	logic [NBR_W-1:0] nbr_cnt;
	logic             alive;
	logic [AGE_W-1:0] next_age;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			line_q <= {line_q[TAPS-2:0], live_in};
		end
	end

	assign nbr = {live_in, line_q[0], line_q[1],
		line_q[LINE-1], line_q[LINE+1],
		line_q[2*LINE-1], line_q[2*LINE], line_q[2*LINE+1]};

	always_comb begin
		nbr_cnt = '0;
		for (int i = 0; i < 8; i++) begin
			nbr_cnt = nbr_cnt + NBR_W'(nbr[i]);
		end
	end

	assign alive = (center_age != '0);

	always_comb begin
		next_age = '0;
		if (alive) begin
			if ((nbr_cnt == NBR_SURVIVE) || (nbr_cnt == NBR_BIRTH)) begin
				next_age = (center_age == AGE_MAX) ? AGE_MAX : center_age + AGE_BORN;
			end
		end else if (nbr_cnt == NBR_BIRTH) begin
			next_age = AGE_BORN;
		end
	end

	assign res.age     = next_age;
	assign res.changed = (next_age != '0) != alive;

endmodule

@@ sv/life_automaton_aging_torus.sv @@
// Top level: request sequencer, ping-pong grid banks and generation counters.
//
// Requests arrive on in_valid/in_stall with cmd, cell_x, cell_y and cell_age_in;
// one result leaves on out_valid/out_stall per request. The block takes one
// request at a time and holds in_stall high from acceptance until its result
// has been taken.
// A cell write, a cell read or an unused code passes through S_ACCESS and
// S_RDATA before its result shows. A generation streams the grid through one
// read port, wrapped by one row and one column on each side, then passes
// through S_DRAIN, S_MUL and S_CMP; a stagnant generation also clears the grid.
// stagnation_weight is written through cfg_valid/cfg_ready/cfg_data, which is
// always ready; write it only while no request is in flight.
// After reset the block clears the grid, one cell a cycle, with in_stall high.
// While out_stall is high the result and all counters hold.
module life_automaton_aging_torus #(
	parameter int GRID_COLS = lat_pkg::GRID_COLS_DEF,
	parameter int GRID_ROWS = lat_pkg::GRID_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [lat_pkg::CMD_W-1:0]    cmd,
	input  logic [lat_pkg::COORD_W-1:0]  cell_x,
	input  logic [lat_pkg::COORD_W-1:0]  cell_y,
	input  logic [lat_pkg::AGE_W-1:0]    cell_age_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [lat_pkg::AGE_W-1:0]    cell_age_out,
	output logic [lat_pkg::CHANGE_W-1:0] changed_cells,
	output logic [lat_pkg::GEN_W-1:0]    generation,
	output logic                         stagnant,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lat_pkg::WEIGHT_W-1:0] cfg_data
);
	import lat_pkg::*;

	localparam int CELLS  = GRID_COLS * GRID_ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int COL_W  = $clog2(GRID_COLS);
	localparam int SJ_W   = $clog2(GRID_COLS + 2);
	localparam int SI_W   = $clog2(GRID_ROWS + 2);
	localparam int PROD_W = CHANGE_W + WEIGHT_W;

	localparam logic [SJ_W-1:0]   SJ_LAST   = SJ_W'(GRID_COLS + 1);
	localparam logic [SI_W-1:0]   SI_LAST   = SI_W'(GRID_ROWS + 1);
	localparam logic [SI_W-1:0]   SI_BOTTOM = SI_W'(GRID_ROWS);
	localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(GRID_COLS - 1);
	localparam logic [ADDR_W-1:0] BASE_TOP  = ADDR_W'((GRID_ROWS - 1) * GRID_COLS);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(GRID_COLS);
	localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_ACCESS = 9'b000000100,
		S_RDATA  = 9'b000001000,
		S_SCAN   = 9'b000010000,
		S_DRAIN  = 9'b000100000,
		S_MUL    = 9'b001000000,
		S_CMP    = 9'b010000000,
		S_OUT    = 9'b100000000
	} state_t;

	state_t              state_q;
	logic                cur_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [ADDR_W-1:0]   idx_q;
	logic                inside_q;
	logic [AGE_W-1:0]    age_in_q;
	logic [AGE_W-1:0]    age_out_q;
	logic [CHANGE_W-1:0] change_q;
	logic [GEN_W-1:0]    gen_q;
	logic                stag_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [PROD_W-1:0]   prod_q;
	logic [ADDR_W-1:0]   clr_q;
	logic                clr_out_q;
	logic [SI_W-1:0]     si_q;
	logic [SJ_W-1:0]     sj_q;
	logic [ADDR_W-1:0]   rbase_q;
	logic [ADDR_W-1:0]   cidx_q;
	logic [CHANGE_W-1:0] acc_q;
	logic                valid_s1;
	logic                win_s1;
	logic [ADDR_W-1:0]   cidx_s1;

	logic [COL_W-1:0]    rcol;
	logic                win;
	logic [ADDR_W-1:0]   rd_addr;
	logic [ADDR_W-1:0]   in_idx;
	logic                in_inside;
	logic [CHANGE_W-1:0] acc_d;
	cell_res_t           res;

	logic                we    [2];
	logic [ADDR_W-1:0]   waddr [2];
	logic [AGE_W-1:0]    wdata [2];
	logic [AGE_W-1:0]    qa    [2];
	logic [AGE_W-1:0]    qb    [2];

	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = (state_q == S_OUT);
	assign cfg_ready     = 1'b1;
	assign cell_age_out  = age_out_q;
	assign changed_cells = change_q;
	assign generation    = gen_q;
	assign stagnant      = stag_q;

	assign in_inside = (int'(cell_x) < GRID_COLS) && (int'(cell_y) < GRID_ROWS);
	assign in_idx    = ADDR_W'(int'(cell_y) * GRID_COLS + int'(cell_x));

	always_comb begin
		priority if (sj_q == '0) begin
			rcol = COL_LAST;
		end else if (sj_q == SJ_LAST) begin
			rcol = '0;
		end else begin
			rcol = COL_W'(sj_q - SJ_W'(1));
		end
	end

	assign win     = (si_q >= SI_W'(2)) && (sj_q >= SJ_W'(2));
	assign rd_addr = (state_q == S_SCAN) ? rbase_q + ADDR_W'(rcol) : idx_q;

	assign acc_d = (valid_s1 && win_s1 && res.changed && (acc_q != CHANGE_MAX)) ?
		acc_q + CHANGE_W'(1) : acc_q;

	always_comb begin
		for (int b = 0; b < 2; b++) begin
			we[b]    = 1'b0;
			waddr[b] = '0;
			wdata[b] = '0;
			if (1'(b) == cur_q) begin
				if (state_q == S_CLEAR) begin
					we[b]    = 1'b1;
					waddr[b] = clr_q;
				end else if ((state_q == S_ACCESS) && (cmd_q == CMD_WRITE) && inside_q) begin
					we[b]    = 1'b1;
					waddr[b] = idx_q;
					wdata[b] = age_in_q;
				end
			end else if (valid_s1 && win_s1) begin
				we[b]    = 1'b1;
				waddr[b] = cidx_s1;
				wdata[b] = res.age;
			end
		end
	end

	for (genvar g = 0; g < 2; g++) begin : g_bank
		lat_bank #(
			.DEPTH  (CELLS),
			.ADDR_W (ADDR_W),
			.DATA_W (AGE_W)
		) u_bank (
			.clk     (clk),
			.we      (we[g]),
			.waddr   (waddr[g]),
			.wdata   (wdata[g]),
			.raddr_a (rd_addr),
			.raddr_b (cidx_q),
			.rdata_a (qa[g]),
			.rdata_b (qb[g])
		);
	end

	lat_cell_unit #(
		.GRID_COLS (GRID_COLS)
	) u_cell_unit (
		.clk        (clk),
		.shift_en   (valid_s1),
		.live_in    (qa[cur_q] != '0),
		.center_age (qb[cur_q]),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			cur_q     <= 1'b0;
			cmd_q     <= '0;
			idx_q     <= '0;
			inside_q  <= 1'b0;
			age_in_q  <= '0;
			age_out_q <= '0;
			change_q  <= '0;
			gen_q     <= '0;
			stag_q    <= 1'b0;
			weight_q  <= WEIGHT_RESET;
			prod_q    <= '0;
			clr_q     <= '0;
			clr_out_q <= 1'b0;
			si_q      <= '0;
			sj_q      <= '0;
			rbase_q   <= '0;
			cidx_q    <= '0;
			acc_q     <= '0;
			valid_s1  <= 1'b0;
			win_s1    <= 1'b0;
			cidx_s1   <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				weight_q <= cfg_data;
			end
			valid_s1 <= (state_q == S_SCAN);
			win_s1   <= win;
			cidx_s1  <= cidx_q;
			acc_q    <= (state_q == S_IDLE) ? '0 : acc_d;

			unique case (state_q)
				S_CLEAR: begin
					if (clr_q == CELL_LAST) begin
						clr_q     <= '0;
						clr_out_q <= 1'b0;
						state_q   <= clr_out_q ? S_OUT : S_IDLE;
					end else begin
						clr_q <= clr_q + ADDR_W'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q     <= cmd;
						idx_q     <= in_idx;
						inside_q  <= in_inside;
						age_in_q  <= cell_age_in;
						age_out_q <= '0;
						stag_q    <= 1'b0;
						si_q      <= '0;
						sj_q      <= '0;
						rbase_q   <= BASE_TOP;
						cidx_q    <= '0;
						state_q   <= (cmd == CMD_STEP) ? S_SCAN : S_ACCESS;
					end
				end
				S_ACCESS: begin
					state_q <= S_RDATA;
				end
				S_RDATA: begin
					if ((cmd_q == CMD_READ) && inside_q) begin
						age_out_q <= qa[cur_q];
					end
					state_q <= S_OUT;
				end
				S_SCAN: begin
					if (win) begin
						cidx_q <= cidx_q + ADDR_W'(1);
					end
					if (sj_q == SJ_LAST) begin
						sj_q <= '0;
						if (si_q == SI_LAST) begin
							state_q <= S_DRAIN;
						end else begin
							si_q <= si_q + SI_W'(1);
							if ((si_q == '0) || (si_q == SI_BOTTOM)) begin
								rbase_q <= '0;
							end else begin
								rbase_q <= rbase_q + ROW_STEP;
							end
						end
					end else begin
						sj_q <= sj_q + SJ_W'(1);
					end
				end
				S_DRAIN: begin
					change_q <= acc_d;
					if (gen_q != '1) begin
						gen_q <= gen_q + GEN_W'(1);
					end
					cur_q   <= ~cur_q;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= PROD_W'(change_q) * PROD_W'(weight_q);
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (GEN_W'(prod_q) < gen_q) begin
						change_q  <= '0;
						gen_q     <= '0;
						stag_q    <= 1'b1;
						clr_q     <= '0;
						clr_out_q <= 1'b1;
						state_q   <= S_CLEAR;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/lat_checker.sv @@
// Port-level checks on the aging life block, bound to its top level.
module lat_port_checks (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [lat_pkg::AGE_W-1:0]    cell_age_out,
	input logic [lat_pkg::CHANGE_W-1:0] changed_cells,
	input logic [lat_pkg::GEN_W-1:0]    generation,
	input logic                         stagnant
);
	import lat_pkg::*;

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid &&
		$stable(cell_age_out) && $stable(changed_cells) &&
		$stable(generation) && $stable(stagnant))
		else $error("stalled result changed");

	a_busy_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("request taken while result pending");

	a_stagnant_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && stagnant |-> (changed_cells == '0) && (generation == '0))
		else $error("stagnant result with live counters");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("result repeated");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !out_valid)
		else $error("result shown in cycle after request");

endmodule

bind life_automaton_aging_torus lat_port_checks u_lat_port_checks (.*);
